>>> design/sts_pkg.sv
// sorted table search package: sizes, action codes, engine states and
// the request/result structs shared by the engine and the top level
`timescale 1ns / 1ps

package sts_pkg;

    // table depth and derived widths
    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // signed walk bounds must hold -1 .. DEPTH
    localparam int SW       = $clog2(DEPTH + 1) + 1;

    // fixed field widths of the ports
    localparam int CFG_W     = 11;
    localparam int IDX_IN_W  = 10;
    localparam int VAL_W     = 32;
    localparam int POS_OUT_W = 11;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_EXACT = 2'd1,
        ACT_LOWER = 2'd2,
        ACT_UPPER = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_CMP,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        action_t               action;
        logic [IDX_IN_W-1:0]   entry_index;
        logic [VAL_W-1:0]      item_value;
    } req_t;

    typedef struct packed {
        logic [POS_OUT_W-1:0]  position;
        logic                  found;
    } res_t;

endpackage

>>> design/sorted_table_search_top.sv
// sorted table search top level: config register, output register, engine
// uses sts_pkg and sts_engine
`timescale 1ns / 1ps

// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------
// input    | in_valid / in_ready  | action, entry_index, item_value
// config   | cfg_valid/cfg_ready  | cfg_data (table_size)
// output   | out_valid/out_ready  | position, found
//
// a load writes the table and gives no result; a query with k halving steps
// passes from its transfer through start, k compares that each issue the next
// table read, done and idle before the next input transfer, and reaches the
// output register as it leaves done; k is at most ceil(log2(table_size + 1)),
// 11 at a full table, and an exact hit ends early
// the table holds garbage after reset until loaded; no clearing pass
// a finished result moves to the output register as soon as it is
// free, so a stalled output holds at most one query inside the engine.

module sorted_table_search_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    action,
    input  logic [sts_pkg::IDX_IN_W-1:0]  entry_index,
    input  logic signed [sts_pkg::VAL_W-1:0] item_value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sts_pkg::CFG_W-1:0]     cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sts_pkg::POS_OUT_W-1:0] position,
    output logic                          found
);

    logic [sts_pkg::CFG_W-1:0]  table_size_reg, table_size_next;
    logic                       out_valid_reg, out_valid_next;
    sts_pkg::res_t              out_res_reg, out_res_next;

    sts_pkg::req_t              req;
    sts_pkg::res_t              eng_res;
    logic                       eng_res_valid;
    logic                       eng_res_ready;

    // user keeps register writes to idle; not enforced, so always take them
    assign cfg_ready = 1'b1;

    always_comb
    begin
        table_size_next = table_size_reg;
        if (cfg_valid && cfg_ready)
        begin
            table_size_next = cfg_data;
        end
    end

    assign req.action      = sts_pkg::action_t'(action);
    assign req.entry_index = entry_index;
    assign req.item_value  = item_value;

    sts_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (in_valid),
        .req_ready  (in_ready),
        .req        (req),
        .table_size (table_size_reg),
        .res_valid  (eng_res_valid),
        .res_ready  (eng_res_ready),
        .res        (eng_res)
    );

    // output register: refill when empty or when its transfer completes
    assign eng_res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (eng_res_valid && eng_res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = eng_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            table_size_reg <= table_size_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign position  = out_res_reg.position;
    assign found     = out_res_reg.found;

endmodule

>>> design/sts_ram.sv
// sorted table search: generic single-port-write, single-port-read ram
// read data registered; no package dependency
`timescale 1ns / 1ps

module sts_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/sts_engine.sv
// sorted table search engine: table memory plus the halving walk
// uses sts_pkg and sts_ram
`timescale 1ns / 1ps

module sts_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  sts_pkg::req_t               req,
    input  logic [sts_pkg::CFG_W-1:0]   table_size,
    output logic                        res_valid,
    input  logic                        res_ready,
    output sts_pkg::res_t               res
);

    sts_pkg::eng_state_t               state_reg, state_next;
    logic signed [sts_pkg::SW-1:0]     lo_reg, lo_next;
    logic signed [sts_pkg::SW-1:0]     hi_reg, hi_next;
    logic signed [sts_pkg::SW-1:0]     mid_reg, mid_next;
    logic signed [sts_pkg::VAL_W-1:0]  key_reg, key_next;
    sts_pkg::action_t                  mode_reg, mode_next;
    sts_pkg::res_t                     res_reg, res_next;

    logic                              wr_en;
    logic                              rd_en;
    logic [sts_pkg::ADDR_W-1:0]        rd_addr;
    logic [sts_pkg::VAL_W-1:0]         rd_data;

    logic [sts_pkg::SW-1:0]            size_sat;
    logic signed [sts_pkg::SW-1:0]     lo_c, hi_c, mid_c, diff_c;
    logic signed [sts_pkg::VAL_W-1:0]  entry;
    logic                              walk, cont, go_right;

    sts_ram #(
        .DEPTH (sts_pkg::DEPTH),
        .WIDTH (sts_pkg::VAL_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (sts_pkg::ADDR_W'(req.entry_index)),
        .wr_data (req.item_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // sizes above the table depth saturate
    always_comb
    begin
        if (32'(table_size) > 32'(sts_pkg::DEPTH))
        begin
            size_sat = sts_pkg::SW'(sts_pkg::DEPTH);
        end
        else
        begin
            size_sat = sts_pkg::SW'(table_size);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        mode_next  = mode_reg;
        res_next   = res_reg;
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        lo_c       = lo_reg;
        hi_c       = hi_reg;
        walk       = 1'b0;
        entry      = $signed(rd_data);
        go_right   = 1'b0;

        unique case (state_reg)
            sts_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req.action == sts_pkg::ACT_LOAD)
                    begin
                        wr_en = (32'(req.entry_index) < 32'(sts_pkg::DEPTH));
                    end
                    else
                    begin
                        mode_next = req.action;
                        key_next  = $signed(req.item_value);
                        if (req.action == sts_pkg::ACT_EXACT)
                        begin
                            lo_next = '0;
                            hi_next = $signed(size_sat) - sts_pkg::SW'(1);
                        end
                        else
                        begin
                            lo_next = '1;
                            hi_next = $signed(size_sat);
                        end
                        state_next = sts_pkg::ST_START;
                    end
                end
            end
            sts_pkg::ST_START:
            begin
                walk = 1'b1;
            end
            sts_pkg::ST_CMP:
            begin
                if (mode_reg == sts_pkg::ACT_EXACT)
                begin
                    if (entry == key_reg)
                    begin
                        res_next.position = sts_pkg::POS_OUT_W'(mid_reg);
                        res_next.found    = 1'b1;
                        state_next        = sts_pkg::ST_DONE;
                    end
                    else
                    begin
                        walk = 1'b1;
                        if (key_reg < entry)
                        begin
                            hi_c = mid_reg - sts_pkg::SW'(1);
                        end
                        else
                        begin
                            lo_c = mid_reg + sts_pkg::SW'(1);
                        end
                    end
                end
                else
                begin
                    walk = 1'b1;
                    if (mode_reg == sts_pkg::ACT_UPPER)
                    begin
                        go_right = (entry <= key_reg);
                    end
                    else
                    begin
                        go_right = (entry < key_reg);
                    end
                    if (go_right)
                    begin
                        lo_c = mid_reg;
                    end
                    else
                    begin
                        hi_c = mid_reg;
                    end
                end
            end
            sts_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = sts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sts_pkg::ST_IDLE;
            end
        endcase

        // next midpoint and loop test from the updated bounds
        diff_c = hi_c - lo_c;
        mid_c  = lo_c + (diff_c >>> 1);
        if (mode_reg == sts_pkg::ACT_EXACT)
        begin
            cont = (lo_c <= hi_c);
        end
        else
        begin
            cont = (diff_c > sts_pkg::SW'(1));
        end
        rd_addr = mid_c[sts_pkg::ADDR_W-1:0];

        if (walk)
        begin
            lo_next = lo_c;
            hi_next = hi_c;
            if (cont)
            begin
                rd_en      = 1'b1;
                mid_next   = mid_c;
                state_next = sts_pkg::ST_CMP;
            end
            else
            begin
                if (mode_reg == sts_pkg::ACT_EXACT)
                begin
                    res_next.position = '0;
                    res_next.found    = 1'b0;
                end
                else
                begin
                    res_next.position = sts_pkg::POS_OUT_W'(hi_c);
                    res_next.found    = 1'b1;
                end
                state_next = sts_pkg::ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        key_reg  <= key_next;
        mode_reg <= mode_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule
